/* design/rcs_pkg.sv */
// ---------------------------------------------------------------------------
// rcs_pkg
// Shared widths, reset constants and the input word type of the
// row-choice closest-sum unit.
// ---------------------------------------------------------------------------
package rcs_pkg;

    // Default sizing of the reachable-sum bitset and of the over-limit sums
    localparam int MAX_TARGET_DFLT = 1024;
    localparam int SUM_BITS_DFLT   = 16;

    // Field widths
    localparam int ELEM_W = 8;
    localparam int TGT_W  = 10;
    localparam int DIFF_W = 16;

    // Reset values
    localparam logic [TGT_W-1:0]  TGT_RESET    = TGT_W'(1);
    localparam logic [ELEM_W-1:0] ROW_MIN_NONE = '1;
    localparam logic [DIFF_W-1:0] DIFF_MAX     = '1;

    // One input word as held in the input register
    typedef struct packed {
        logic [ELEM_W-1:0] elem_value;
        logic              row_end;
        logic              matrix_end;
    } t_item;

endpackage

/* design/rcs_item_if.sv */
// ---------------------------------------------------------------------------
// rcs_item_if
// Valid/ready channel that carries one matrix element with its row and
// matrix end marks.
// ---------------------------------------------------------------------------
interface rcs_item_if;
    import rcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] elem_value;
    logic              row_end;
    logic              matrix_end;

    modport source (output valid, output elem_value, output row_end,
                    output matrix_end, input ready);
    modport sink   (input valid, input elem_value, input row_end,
                    input matrix_end, output ready);

endinterface

/* design/rcs_result_if.sv */
// ---------------------------------------------------------------------------
// rcs_result_if
// Valid/ready channel that carries the closest distance of one matrix.
// ---------------------------------------------------------------------------
interface rcs_result_if;
    import rcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIFF_W-1:0] min_difference;

    modport source (output valid, output min_difference, input ready);
    modport sink   (input valid, input min_difference, output ready);

endinterface

/* design/rcs_lsb_find.sv */
// ---------------------------------------------------------------------------
// rcs_lsb_find
// Lowest set bit of a vector: isolate it with a two's complement mask and
// encode the one-hot result to a binary index.
// ---------------------------------------------------------------------------
module rcs_lsb_find #(
    parameter int  W  = 16,
    localparam int IW = $clog2(W)
) (
    input  logic [W-1:0]  i_vec,
    output logic          o_found,
    output logic [IW-1:0] o_index
);

    logic [W-1:0] onehot;

    // Keep only the lowest set bit
    assign onehot  = i_vec & (~i_vec + W'(1));
    assign o_found = |i_vec;

    // Encode the one-hot vector
    always_comb begin
        o_index = '0;
        for (int k = 0; k < W; k++) begin
            if (onehot[k]) begin
                o_index = o_index | IW'(k);
            end
        end
    end

endmodule

/* design/rcs_step.sv */
// ---------------------------------------------------------------------------
// rcs_step
// Per-word update of the reachable-sum bitset, the least over-limit sums and
// the row minimum; row commit, matrix clear and the end-of-matrix snapshot.
// ---------------------------------------------------------------------------
module rcs_step #(
    parameter int MAX_TARGET = rcs_pkg::MAX_TARGET_DFLT,
    parameter int SUM_BITS   = rcs_pkg::SUM_BITS_DFLT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  rcs_pkg::t_item             i_item,
    input  logic [rcs_pkg::TGT_W-1:0]  i_target_sum,
    output logic                       o_snap_valid,
    output logic [MAX_TARGET-1:0]      o_snap_bits,
    output logic [SUM_BITS-1:0]        o_snap_over,
    output logic [rcs_pkg::TGT_W-1:0]  o_snap_target
);
    import rcs_pkg::*;

    localparam int AW  = $clog2(MAX_TARGET);
    // Shifted bitset spans every sum s + e
    localparam int XW  = MAX_TARGET + (1 << ELEM_W) - 1;
    localparam int XIW = $clog2(XW);
    localparam int CM0 = (SUM_BITS > XIW) ? SUM_BITS : XIW;
    localparam int CW  = ((CM0 > TGT_W) ? CM0 : TGT_W) + 1;
    localparam logic [SUM_BITS-1:0] SUM_NONE = '1;
    localparam logic [CW-1:0]       SUM_SAT  = CW'(SUM_NONE) - CW'(1);

    // State
    logic [MAX_TARGET-1:0] r_reach_now;
    logic [MAX_TARGET-1:0] r_reach_next;
    logic [SUM_BITS-1:0]   r_over_now;
    logic [SUM_BITS-1:0]   r_over_next;
    logic [ELEM_W-1:0]     r_row_min;
    logic                  r_snap_valid;
    logic [MAX_TARGET-1:0] r_snap_bits;
    logic [SUM_BITS-1:0]   r_snap_over;
    logic [TGT_W-1:0]      r_snap_target;

    // Next values and datapath
    logic [CW-1:0]         lim;
    logic [MAX_TARGET-1:0] lo_mask;
    logic [XW-1:0]         hi_mask;
    logic [MAX_TARGET-1:0] cur;
    logic [XW-1:0]         spread;
    logic                  hit_found;
    logic [XIW-1:0]        hit_idx;
    logic                  above_found;
    logic [AW-1:0]         above_idx;
    logic [CW-1:0]         best;
    logic [CW-1:0]         carry_sum;
    logic [CW-1:0]         over_item;
    logic [CW-1:0]         over_commit;
    logic [MAX_TARGET-1:0] n_reach_next;
    logic [SUM_BITS-1:0]   n_over_next;
    logic [SUM_BITS-1:0]   n_over_commit;
    logic [ELEM_W-1:0]     n_row_min;
    logic                  row_done;

    // Bitset limit and masks below and at or above it
    always_comb begin
        if (CW'(i_target_sum) < CW'(MAX_TARGET)) begin
            lim = CW'(i_target_sum);
        end else begin
            lim = CW'(MAX_TARGET);
        end
        for (int s = 0; s < MAX_TARGET; s++) begin
            lo_mask[s] = CW'(s) < lim;
        end
        for (int t = 0; t < XW; t++) begin
            hi_mask[t] = CW'(t) >= lim;
        end
    end

    // Shift the live sums by the element
    assign cur          = r_reach_now & lo_mask;
    assign spread       = XW'(cur) << i_item.elem_value;
    assign n_reach_next = r_reach_next | (spread[MAX_TARGET-1:0] & lo_mask);

    // Least new sum at or above the limit
    rcs_lsb_find #(.W(XW)) u_hit_find (
        .i_vec   (spread & hi_mask),
        .o_found (hit_found),
        .o_index (hit_idx)
    );

    // Least stale set bit at or above the limit, for the row commit
    rcs_lsb_find #(.W(MAX_TARGET)) u_above_find (
        .i_vec   (r_reach_now & ~lo_mask),
        .o_found (above_found),
        .o_index (above_idx)
    );

    assign row_done = i_item.row_end | i_item.matrix_end;

    // Fold the item into the running over-limit minimum and row minimum
    always_comb begin
        over_item = CW'(r_over_next);
        if (hit_found && (CW'(hit_idx) < over_item)) begin
            over_item = CW'(hit_idx);
        end
        n_over_next = over_item[SUM_BITS-1:0];
        if (i_item.elem_value < r_row_min) begin
            n_row_min = i_item.elem_value;
        end else begin
            n_row_min = r_row_min;
        end
    end

    // Carry the least committed over-limit sum through the row minimum
    always_comb begin
        best = CW'(r_over_now);
        if (above_found && (CW'(above_idx) < best)) begin
            best = CW'(above_idx);
        end
        carry_sum = best + CW'(n_row_min);
        if (carry_sum > SUM_SAT) begin
            carry_sum = SUM_SAT;
        end
        over_commit = over_item;
        if ((best != CW'(SUM_NONE)) && (carry_sum < over_commit)) begin
            over_commit = carry_sum;
        end
        n_over_commit = over_commit[SUM_BITS-1:0];
    end

    // Advance state: accumulate, commit at row end, clear at matrix end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach_now  <= MAX_TARGET'(1);
            r_reach_next <= '0;
            r_over_now   <= SUM_NONE;
            r_over_next  <= SUM_NONE;
            r_row_min    <= ROW_MIN_NONE;
            r_snap_valid <= 1'b0;
        end else if (i_en) begin
            r_snap_valid <= i_valid & i_item.matrix_end;
            if (i_valid) begin
                if (i_item.matrix_end) begin
                    r_reach_now  <= MAX_TARGET'(1);
                    r_reach_next <= '0;
                    r_over_now   <= SUM_NONE;
                    r_over_next  <= SUM_NONE;
                    r_row_min    <= ROW_MIN_NONE;
                end else if (row_done) begin
                    r_reach_now  <= n_reach_next;
                    r_reach_next <= '0;
                    r_over_now   <= n_over_commit;
                    r_over_next  <= SUM_NONE;
                    r_row_min    <= ROW_MIN_NONE;
                end else begin
                    r_reach_next <= n_reach_next;
                    r_over_next  <= n_over_next;
                    r_row_min    <= n_row_min;
                end
            end
        end
    end

    // Capture the committed state of a finished matrix
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && i_item.matrix_end) begin
            r_snap_bits   <= n_reach_next;
            r_snap_over   <= n_over_commit;
            r_snap_target <= i_target_sum;
        end
    end

    assign o_snap_valid  = r_snap_valid;
    assign o_snap_bits   = r_snap_bits;
    assign o_snap_over   = r_snap_over;
    assign o_snap_target = r_snap_target;

endmodule

/* design/rcs_dist.sv */
// ---------------------------------------------------------------------------
// rcs_dist
// Closest distance to the target over a committed bitset and its least
// over-limit sum, saturated to the result width.
// ---------------------------------------------------------------------------
module rcs_dist #(
    parameter int MAX_TARGET = rcs_pkg::MAX_TARGET_DFLT,
    parameter int SUM_BITS   = rcs_pkg::SUM_BITS_DFLT
) (
    input  logic [MAX_TARGET-1:0]      i_bits,
    input  logic [SUM_BITS-1:0]        i_over,
    input  logic [rcs_pkg::TGT_W-1:0]  i_target,
    output logic [rcs_pkg::DIFF_W-1:0] o_distance
);
    import rcs_pkg::*;

    localparam int AW  = $clog2(MAX_TARGET);
    localparam int CM0 = (SUM_BITS > AW) ? SUM_BITS : AW;
    localparam int CW  = ((CM0 > DIFF_W) ? CM0 : DIFF_W) + 1;
    localparam logic [SUM_BITS-1:0] SUM_NONE = '1;

    logic [MAX_TARGET-1:0] below_mask;
    logic [MAX_TARGET-1:0] below_rev;
    logic                  below_found;
    logic [AW-1:0]         below_idx;
    logic                  above_found;
    logic [AW-1:0]         above_idx;
    logic [CW-1:0]         tgt;
    logic [CW-1:0]         below_sum;
    logic [CW-1:0]         over_sum;
    logic [CW-1:0]         gap;
    logic [CW-1:0]         dist_min;

    assign tgt = CW'(i_target);

    // Split the set bits at the target; reverse the lower part for a
    // highest-bit search
    always_comb begin
        for (int s = 0; s < MAX_TARGET; s++) begin
            below_mask[s] = CW'(s) < tgt;
        end
        for (int k = 0; k < MAX_TARGET; k++) begin
            below_rev[k] = i_bits[MAX_TARGET-1-k] & below_mask[MAX_TARGET-1-k];
        end
    end

    rcs_lsb_find #(.W(MAX_TARGET)) u_below_find (
        .i_vec   (below_rev),
        .o_found (below_found),
        .o_index (below_idx)
    );

    rcs_lsb_find #(.W(MAX_TARGET)) u_above_find (
        .i_vec   (i_bits & ~below_mask),
        .o_found (above_found),
        .o_index (above_idx)
    );

    assign below_sum = CW'(MAX_TARGET - 1) - CW'(below_idx);
    assign over_sum  = CW'(i_over);

    // Take the least of the three candidate distances
    always_comb begin
        dist_min = CW'(DIFF_MAX);
        if (below_found && ((tgt - below_sum) < dist_min)) begin
            dist_min = tgt - below_sum;
        end
        if (above_found && ((CW'(above_idx) - tgt) < dist_min)) begin
            dist_min = CW'(above_idx) - tgt;
        end
        if (over_sum < tgt) begin
            gap = tgt - over_sum;
        end else begin
            gap = over_sum - tgt;
        end
        if ((i_over != SUM_NONE) && (gap < dist_min)) begin
            dist_min = gap;
        end
        o_distance = dist_min[DIFF_W-1:0];
    end

endmodule

/* design/row_choice_sum_closest_target_unit.sv */
// A matrix end passes the input, snapshot and result registers in turn.
// Throughput: one word per cycle while no result waits untaken; the shift-OR
// and lowest-bit encoders are combinational, so the loop closes every cycle.
// A stalled result register holds the whole pipeline and drops ready.
// Reset (synchronous, active low): only sum zero reachable, no over-limit
// sums, target 1, no result pending.
// ---------------------------------------------------------------------------
// row_choice_sum_closest_target_unit
// Streams a matrix one element per word and returns, at the matrix end, the
// least distance of a one-pick-per-row sum from the configured target.
// ---------------------------------------------------------------------------
module row_choice_sum_closest_target_unit #(
    parameter int MAX_TARGET = rcs_pkg::MAX_TARGET_DFLT,
    parameter int SUM_BITS   = rcs_pkg::SUM_BITS_DFLT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rcs_item_if.sink                  i_item,
    rcs_result_if.source              o_result,
    input  logic                      i_cfg_wr_en,
    input  logic [rcs_pkg::TGT_W-1:0] i_cfg_wr_data
);
    import rcs_pkg::*;

    logic                  en;
    logic [TGT_W-1:0]      r_target_sum;
    logic                  r_in_valid;
    t_item                 r_in;
    logic                  snap_valid;
    logic [MAX_TARGET-1:0] snap_bits;
    logic [SUM_BITS-1:0]   snap_over;
    logic [TGT_W-1:0]      snap_target;
    logic [DIFF_W-1:0]     n_distance;
    logic                  r_out_valid;
    logic [DIFF_W-1:0]     r_out_dist;

    // Advance the pipeline unless a result waits untaken
    assign en           = ~r_out_valid | o_result.ready;
    assign i_item.ready = en;

    // Target register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_sum <= TGT_RESET;
        end else if (i_cfg_wr_en) begin
            r_target_sum <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_item.valid) begin
            r_in.elem_value <= i_item.elem_value;
            r_in.row_end    <= i_item.row_end;
            r_in.matrix_end <= i_item.matrix_end;
        end
    end

    rcs_step #(
        .MAX_TARGET (MAX_TARGET),
        .SUM_BITS   (SUM_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (r_in_valid),
        .i_item        (r_in),
        .i_target_sum  (r_target_sum),
        .o_snap_valid  (snap_valid),
        .o_snap_bits   (snap_bits),
        .o_snap_over   (snap_over),
        .o_snap_target (snap_target)
    );

    rcs_dist #(
        .MAX_TARGET (MAX_TARGET),
        .SUM_BITS   (SUM_BITS)
    ) u_dist (
        .i_bits     (snap_bits),
        .i_over     (snap_over),
        .i_target   (snap_target),
        .o_distance (n_distance)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && snap_valid) begin
            r_out_dist <= n_distance;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.min_difference = r_out_dist;

    // A matrix end moving out of the input register yields a snapshot
    a_end_makes_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_in_valid && r_in.matrix_end) |=> snap_valid)
        else $error("matrix end word produced no snapshot");

    // A snapshot moving on always becomes a result
    a_snap_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && snap_valid) |=> r_out_valid)
        else $error("snapshot was not passed to the result register");

    // No result appears without a snapshot behind it
    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !snap_valid) |=> !r_out_valid)
        else $error("result raised without a snapshot");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams random and hand-built matrices into the row-choice closest-sum
// unit under several target settings and idle patterns, predicts each
// closest distance with a bitset model of its own and checks every result
// word in order.
// ---------------------------------------------------------------------------
module testbench;
    import rcs_pkg::*;

    localparam int MAX_T    = MAX_TARGET_DFLT;
    localparam int SUM_NONE = (1 << SUM_BITS_DFLT) - 1;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [TGT_W-1:0] cfg_wr_data;

    rcs_item_if   item_bus ();
    rcs_result_if result_bus ();

    row_choice_sum_closest_target_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item_bus),
        .o_result      (result_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Words waiting to be sent, and closest distances still to come back
    t_item             word_q[$];
    logic [DIFF_W-1:0] dist_q[$];

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned words_queued;
    int unsigned errors;

    // Shadow state of the closest-sum search
    bit               reach_now[MAX_T];
    bit               reach_next[MAX_T];
    int unsigned      over_now;
    int unsigned      over_next;
    int unsigned      row_min;
    logic [TGT_W-1:0] tgt_now;

    // Return the matrix state to its empty form; the target stays
    function automatic void matrix_restart();
        foreach (reach_now[s]) begin
            reach_now[s]  = 1'b0;
            reach_next[s] = 1'b0;
        end
        reach_now[0] = 1'b1;
        over_now     = SUM_NONE;
        over_next    = SUM_NONE;
        row_min      = 32'(ROW_MIN_NONE);
    endfunction

    // Advance the search by one word; return 1 when a distance comes out
    function automatic bit closest_sum_step(input t_item w,
                                            output logic [DIFF_W-1:0] dist_out);
        int unsigned lim, e, t, best, c, d, x, tg, s;
        e        = 32'(w.elem_value);
        tg       = 32'(tgt_now);
        lim      = (tg < MAX_T) ? tg : MAX_T;
        dist_out = '0;
        // extend every committed sum below the limit by this element
        for (s = 0; s < lim; s++) begin
            if (reach_now[s]) begin
                t = s + e;
                if (t < lim)
                    reach_next[t] = 1'b1;
                else if (t < over_next)
                    over_next = t;
            end
        end
        if (e < row_min)
            row_min = e;
        // commit the row; carry the least over-limit sum by the row minimum
        if (w.row_end || w.matrix_end) begin
            best = over_now;
            for (s = lim; s < MAX_T; s++) begin
                if (reach_now[s] && s < best)
                    best = s;
            end
            if (best != SUM_NONE) begin
                c = best + row_min;
                if (c > SUM_NONE - 1)
                    c = SUM_NONE - 1;
                if (c < over_next)
                    over_next = c;
            end
            reach_now = reach_next;
            foreach (reach_next[k])
                reach_next[k] = 1'b0;
            over_now  = over_next;
            over_next = SUM_NONE;
            row_min   = 32'(ROW_MIN_NONE);
        end
        if (!w.matrix_end)
            return 1'b0;
        // pick the closest reachable sum
        d = 32'(DIFF_MAX);
        for (s = 0; s < MAX_T; s++) begin
            if (reach_now[s]) begin
                x = (s < tg) ? tg - s : s - tg;
                if (x < d)
                    d = x;
            end
        end
        if (over_now != SUM_NONE) begin
            x = (over_now < tg) ? tg - over_now : over_now - tg;
            if (x < d)
                d = x;
        end
        dist_out = d[DIFF_W-1:0];
        matrix_restart();
        return 1'b1;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive words from the pending queue; predict each accepted word
    always @(posedge i_clk) begin : drive_words
        t_item             w;
        logic [DIFF_W-1:0] d;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else begin
            if (item_bus.valid && item_bus.ready) begin
                w.elem_value = item_bus.elem_value;
                w.row_end    = item_bus.row_end;
                w.matrix_end = item_bus.matrix_end;
                if (closest_sum_step(w, d))
                    dist_q = {dist_q, d};
            end
            if (!item_bus.valid || item_bus.ready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    w = word_q.pop_front();
                    item_bus.valid      <= 1'b1;
                    item_bus.elem_value <= w.elem_value;
                    item_bus.row_end    <= w.row_end;
                    item_bus.matrix_end <= w.matrix_end;
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Take result words, stall at random, compare with the oldest expectation
    always @(posedge i_clk) begin : check_results
        logic [DIFF_W-1:0] exp_d;
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                if (dist_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word: min_difference %0d",
                                 result_bus.min_difference);
                end else begin
                    exp_d = dist_q.pop_front();
                    if (exp_d !== result_bus.min_difference) begin
                        errors++;
                        if (errors <= 10)
                            $display("min_difference mismatch: expected %0d, actual %0d",
                                     exp_d, result_bus.min_difference);
                    end
                end
            end
            result_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Hold until every queued word is sent and every distance has come back
    task automatic drain_results();
        while (word_q.size() != 0 || item_bus.valid || dist_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the target while the unit is idle
    task automatic set_target(input int unsigned value);
        drain_results();
        repeat (8) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[TGT_W-1:0];
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        tgt_now = value[TGT_W-1:0];
    endtask

    task automatic put_word(input int unsigned e, input bit re, input bit me);
        t_item w;
        w.elem_value = e[ELEM_W-1:0];
        w.row_end    = re;
        w.matrix_end = me;
        word_q = {word_q, w};
        words_queued++;
    endtask

    // Queue one random matrix; now and then the matrix end carries no row end
    task automatic queue_matrix(input int unsigned rows, input int unsigned max_len);
        int unsigned len, e;
        bit          lone_end, last;
        lone_end = ($urandom_range(9) == 0);
        for (int unsigned r = 0; r < rows; r++) begin
            len = $urandom_range(1, max_len);
            for (int unsigned k = 0; k < len; k++) begin
                case ($urandom_range(3))
                    0: e = $urandom_range(0, 31);
                    1: e = $urandom_range(0, 255);
                    2: e = $urandom_range(1) ? 255 : 0;
                    default: e = $urandom_range(64, 200);
                endcase
                last = (r == rows - 1) && (k == len - 1);
                put_word(e, (k == len - 1) && !(last && lone_end), last);
            end
        end
    endtask

    function automatic int unsigned pick_target();
        case ($urandom_range(4))
            0: return ($urandom_range(1) ? 1023 : 0);
            1: return $urandom_range(1, 1023);
            2: return $urandom_range(1, 120);
            3: return $urandom_range(300, 1023);
            default: return 1;
        endcase
    endfunction

    // Main sequence
    initial begin
        int unsigned goal, mats;
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        item_bus.valid      = 1'b0;
        item_bus.elem_value = '0;
        item_bus.row_end    = 1'b0;
        item_bus.matrix_end = 1'b0;
        result_bus.ready    = 1'b0;
        src_idle_pct        = 0;
        snk_stall_pct       = 0;
        words_queued        = 0;
        errors              = 0;
        tgt_now             = TGT_RESET;
        matrix_restart();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset target, single words, matrix end without row end
        put_word(0, 1, 1);
        put_word(255, 0, 1);
        put_word(1, 0, 0);
        put_word(0, 1, 0);
        put_word(0, 1, 1);
        // largest target with extreme elements
        set_target(1023);
        put_word(255, 0, 0);
        put_word(128, 1, 0);
        put_word(255, 0, 0);
        put_word(254, 1, 0);
        put_word(255, 0, 0);
        put_word(0, 0, 0);
        put_word(17, 1, 0);
        put_word(255, 0, 0);
        put_word(255, 1, 1);
        // zero target: answer is the sum of row minimums
        set_target(0);
        put_word(5, 0, 0);
        put_word(3, 1, 0);
        put_word(7, 0, 0);
        put_word(9, 1, 1);
        // lower the target mid-matrix so committed sums sit above the limit
        set_target(600);
        put_word(200, 0, 0);
        put_word(100, 1, 0);
        put_word(250, 0, 0);
        put_word(50, 1, 0);
        set_target(100);
        put_word(10, 0, 0);
        put_word(0, 1, 1);

        // long chain of row minimums under target zero drives the sum to saturation
        set_target(0);
        for (int i = 0; i < 260; i++)
            put_word(255, 1, i == 259);

        // random matrices over four idle patterns, two targets each
        for (int p = 0; p < 4; p++) begin
            for (int h = 0; h < 2; h++) begin
                set_target(pick_target());
                case (p)
                    0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                    1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
                    2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
                    default: begin src_idle_pct = 36; snk_stall_pct = 36; end
                endcase
                goal = words_queued + 250;
                mats = 0;
                while (words_queued < goal) begin
                    queue_matrix($urandom_range(1, 6), $urandom_range(1, 5));
                    mats++;
                    // pause the sender until the pipeline is empty
                    if (p == 0 && mats % 12 == 0)
                        drain_results();
                end
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && dist_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
design/rcs_pkg.sv
design/rcs_item_if.sv
design/rcs_result_if.sv
design/rcs_lsb_find.sv
design/rcs_step.sv
design/rcs_dist.sv
design/row_choice_sum_closest_target_unit.sv
tb/sv/testbench.sv
